FILE: sv/isu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isu_pkg
// Shared constants and controller/datapath interface types for the
// interval set union block.
// ----------------------------------------------------------------------------
package isu_pkg;

	localparam int MAX_INTERVALS = 32;
	localparam int POS_BITS      = 16;
	localparam int IDX_BITS      = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int CNT_BITS      = 6;
	// write index may run one past a full table during an overflowing add
	localparam int WIDX_BITS     = $clog2(MAX_INTERVALS + 2);
	localparam int ENT_BITS      = 2 * POS_BITS;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef logic [POS_BITS-1:0] pos_t;
	typedef logic [CNT_BITS-1:0] cnt_t;

	typedef struct packed {
		logic load;     // latch an add transaction and arm the merge pass
		logic clear;    // empty the table
		logic span;     // full-span add: table untouched, report covered
		logic scan;     // stream the table through the merge stage
		logic commit;   // finish the pass and swap banks unless the add overflowed
		logic out_load; // move the result into the output register
	} isu_cmd_t;

	typedef struct packed {
		logic full_span;
		logic scan_done;
	} isu_sts_t;

endpackage

FILE: sv/interval_set_union.sv
`timescale 1ns / 1ps
// An add streams the stored table through the merge stage in ST_SCAN, holding an
// entry that the new interval lands ahead of while the merged one is written, then
// passes ST_COMMIT and ST_RESP; a clear or full-span add goes straight to ST_RESP.
// One transaction at a time: in_ready rises with out_valid, and ST_RESP waits
// while an earlier result is unaccepted. Reset: arst_n empties the table and
// idles both channels; table contents are not cleared, only the stored count.
// ----------------------------------------------------------------------------
// interval_set_union
// Sorted table of disjoint closed intervals with merge-on-add and a
// full-coverage report.
// ----------------------------------------------------------------------------
module interval_set_union (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 opcode,
	input  isu_pkg::pos_t        lower_pos,
	input  isu_pkg::pos_t        upper_pos,
	input  isu_pkg::pos_t        line_end,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 full_coverage,
	output logic                 table_full,
	output isu_pkg::cnt_t        interval_count
);

	isu_pkg::isu_cmd_t cmd;
	isu_pkg::isu_sts_t sts;

	isu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	isu_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.lower_pos      (lower_pos),
		.upper_pos      (upper_pos),
		.line_end       (line_end),
		.full_coverage  (full_coverage),
		.table_full     (table_full),
		.interval_count (interval_count)
	);

endmodule

FILE: sv/isu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isu_ctrl
// Sequencer for the interval set union: accepts transactions, steps the
// datapath through the merge pass and owns the output handshake.
// ----------------------------------------------------------------------------
module isu_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             opcode,
	output logic             out_valid,
	input  logic             out_ready,
	output isu_pkg::isu_cmd_t cmd,
	input  isu_pkg::isu_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   is_add;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign is_add    = (opcode == isu_pkg::OP_ADD);

	always_comb begin
		cmd          = '0;
		cmd.load     = accept && is_add && !sts.full_span;
		cmd.clear    = accept && (opcode == isu_pkg::OP_CLEAR);
		cmd.span     = accept && is_add && sts.full_span;
		cmd.scan     = (state_q == ST_SCAN);
		cmd.commit   = (state_q == ST_COMMIT);
		cmd.out_load = (state_q == ST_RESP) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= cmd.load ? ST_SCAN : ST_RESP;
					end
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: sv/isu_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isu_datapath
// Two-bank interval table with a streaming merge stage. A non-full-span add
// copies the live bank into the spare bank, folding overlapped entries into one
// and inserting the new interval in order; banks swap unless the add overflowed.
// ----------------------------------------------------------------------------
module isu_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  isu_pkg::isu_cmd_t cmd,
	output isu_pkg::isu_sts_t sts,
	input  isu_pkg::pos_t     lower_pos,
	input  isu_pkg::pos_t     upper_pos,
	input  isu_pkg::pos_t     line_end,
	output logic              full_coverage,
	output logic              table_full,
	output isu_pkg::cnt_t     interval_count
);

	localparam int P = isu_pkg::POS_BITS;
	localparam int N = isu_pkg::MAX_INTERVALS;
	localparam int I = isu_pkg::IDX_BITS;
	localparam int W = isu_pkg::WIDX_BITS;
	localparam int C = isu_pkg::CNT_BITS;
	localparam int E = isu_pkg::ENT_BITS;

	// bank select is the top address bit
	logic [E-1:0] mem [2*N];

	logic [E-1:0] rdata_s1;
	logic         dv_s1;
	logic [C-1:0] rd_idx_q;
	logic [W-1:0] wr_idx_q;
	logic [C-1:0] count_q;
	logic         bank_q;
	logic         emitted_q;
	logic         found_q;
	logic [P-1:0] a_q;
	logic [P-1:0] b_q;
	logic [P-1:0] lo_q;
	logic [P-1:0] hi_q;
	logic [P-1:0] end_q;
	logic         res_cov_q;
	logic         res_full_q;

	logic [P-1:0] a_min;
	logic [P-1:0] b_max;
	logic [P-1:0] ent_lo;
	logic [P-1:0] ent_hi;
	logic         below;
	logic         overlap;
	logic         consume;
	logic         emit_merge;
	logic         issue;
	logic         scan_wr;
	logic         wr_en;
	logic [E-1:0] wr_data;
	logic         ovf;
	logic [W-1:0] final_cnt;
	logic         wr_room;

	always_comb begin
		a_min      = (lower_pos > upper_pos) ? upper_pos : lower_pos;
		b_max      = (lower_pos > upper_pos) ? lower_pos : upper_pos;
		sts.full_span = (a_min == '0) && (b_max == line_end);

		ent_lo     = rdata_s1[E-1:P];
		ent_hi     = rdata_s1[P-1:0];
		below      = ent_hi < a_q;
		overlap    = !below && (ent_lo <= b_q);
		// an entry past the new interval is held while the merged one is written
		emit_merge = dv_s1 && !below && !overlap && !emitted_q;
		consume    = dv_s1 && !emit_merge;
		issue      = cmd.scan && (!dv_s1 || consume) && (rd_idx_q < count_q);
		sts.scan_done = !dv_s1 && (rd_idx_q == count_q);

		ovf        = !found_q && (count_q == C'(N));
		final_cnt  = wr_idx_q + W'(!emitted_q);
		wr_room    = wr_idx_q < W'(N);

		scan_wr    = cmd.scan && dv_s1 && !overlap;
		wr_en      = wr_room && (scan_wr || (cmd.commit && !emitted_q));
		wr_data    = (cmd.commit || emit_merge) ? {lo_q, hi_q} : rdata_s1;
	end

	// table storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{~bank_q, wr_idx_q[I-1:0]}] <= wr_data;
		end
		if (issue) begin
			rdata_s1 <= mem[{bank_q, rd_idx_q[I-1:0]}];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s1     <= 1'b0;
			rd_idx_q  <= '0;
			wr_idx_q  <= '0;
			count_q   <= '0;
			bank_q    <= 1'b0;
			emitted_q <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				dv_s1     <= 1'b0;
				rd_idx_q  <= '0;
				wr_idx_q  <= '0;
				emitted_q <= 1'b0;
				found_q   <= 1'b0;
			end else if (cmd.scan) begin
				if (issue) begin
					dv_s1    <= 1'b1;
					rd_idx_q <= rd_idx_q + C'(1);
				end else if (consume) begin
					dv_s1 <= 1'b0;
				end
				if (scan_wr) begin
					wr_idx_q <= wr_idx_q + W'(1);
				end
				if (emit_merge) begin
					emitted_q <= 1'b1;
				end
				if (dv_s1 && overlap) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.commit && !ovf) begin
				count_q <= final_cnt[C-1:0];
				bank_q  <= ~bank_q;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q   <= a_min;
			b_q   <= b_max;
			lo_q  <= a_min;
			hi_q  <= b_max;
			end_q <= line_end;
		end else if (cmd.scan && dv_s1 && overlap) begin
			if (ent_lo < lo_q) begin
				lo_q <= ent_lo;
			end
			if (ent_hi > hi_q) begin
				hi_q <= ent_hi;
			end
		end
		if (cmd.clear) begin
			res_cov_q  <= 1'b0;
			res_full_q <= 1'b0;
		end else if (cmd.span) begin
			res_cov_q  <= 1'b1;
			res_full_q <= 1'b0;
		end else if (cmd.commit) begin
			res_cov_q  <= !ovf && (lo_q == '0) && (hi_q >= end_q);
			res_full_q <= ovf;
		end
		if (cmd.out_load) begin
			full_coverage  <= res_cov_q;
			table_full     <= res_full_q;
			interval_count <= count_q;
		end
	end

endmodule
